[hw/rtl/sse_pkg.sv]
// Shared types and constants for the selection sort engine.
package sse_pkg;

    // Default capacity of the value store.
    localparam int SSE_MAX_ITEMS = 64;

    // Width of one stored value.
    localparam int SSE_DW = 32;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_LOAD,
        ST_POS,
        ST_FIRST,
        ST_SCAN,
        ST_SWAP_A,
        ST_SWAP_B,
        ST_ORD,
        ST_OEMIT,
        ST_OWAIT
    } t_state;

endpackage

[hw/rtl/selection_sort_engine_unit.sv]
// Items are stored as they are loaded; sorting then runs on the single compare fed from
// the store's one read port, one entry per cycle while scanning.
// Results then follow one at a time, each held until the output side takes it.
// Throughput: one set at a time; input is not ready from the closing item until the
// final result is taken.
// Reset is synchronous, active low: clears state, fill count, drop flag and output valid, not the store.
module selection_sort_engine_unit
    import sse_pkg::*;
#(
    parameter int MAX_ITEMS = SSE_MAX_ITEMS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [SSE_DW-1:0] i_item_value,
    input  logic                     i_is_last,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [SSE_DW-1:0] o_sorted_value,
    output logic                     o_is_final,
    output logic                     o_overflowed
);

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic signed [SSE_DW-1:0] mem_wdata;
    logic [AW-1:0]            mem_raddr;
    logic signed [SSE_DW-1:0] mem_rdata;

    // Sequencer with the shared compare.
    sse_seq #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_item_value   (i_item_value),
        .i_is_last      (i_is_last),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_sorted_value (o_sorted_value),
        .o_is_final     (o_is_final),
        .o_overflowed   (o_overflowed),
        .o_we           (mem_we),
        .o_waddr        (mem_waddr),
        .o_wdata        (mem_wdata),
        .o_raddr        (mem_raddr),
        .i_rdata        (mem_rdata)
    );

    // Value store.
    sse_store #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

[hw/rtl/sse_store.sv]
// Value store: one write port and one read port with registered read data.
module sse_store
    import sse_pkg::*;
#(
    parameter int MAX_ITEMS = SSE_MAX_ITEMS,
    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [AW-1:0]            i_waddr,
    input  logic signed [SSE_DW-1:0] i_wdata,
    input  logic [AW-1:0]            i_raddr,
    output logic signed [SSE_DW-1:0] o_rdata
);

    logic signed [SSE_DW-1:0] r_mem [MAX_ITEMS];
    logic signed [SSE_DW-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data registered and available in the cycle after the address.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/sse_seq.sv]
// Sequencer: loads items, runs the selection sort over the store, emits results.
module sse_seq
    import sse_pkg::*;
#(
    parameter int MAX_ITEMS = SSE_MAX_ITEMS,
    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1,
    localparam int CW = AW + 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Input channel
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [SSE_DW-1:0] i_item_value,
    input  logic                     i_is_last,
    // Output channel
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [SSE_DW-1:0] o_sorted_value,
    output logic                     o_is_final,
    output logic                     o_overflowed,
    // Store port
    output logic                     o_we,
    output logic [AW-1:0]            o_waddr,
    output logic signed [SSE_DW-1:0] o_wdata,
    output logic [AW-1:0]            o_raddr,
    input  logic signed [SSE_DW-1:0] i_rdata
);

    t_state r_state, n_state;

    logic [CW-1:0]            r_cnt;
    logic                     r_drop;
    logic [AW-1:0]            r_pos;
    logic [CW-1:0]            r_scan;
    logic [AW-1:0]            r_idx;
    logic [AW-1:0]            r_min_at;
    logic signed [SSE_DW-1:0] r_min_val;
    logic signed [SSE_DW-1:0] r_pos_val;
    logic                     r_out_vld;
    logic signed [SSE_DW-1:0] r_out_val;
    logic                     r_out_final;
    logic                     r_out_ovf;

    logic          in_acc;
    logic          out_acc;
    logic          has_room;
    logic [CW-1:0] n_cnt;
    logic [CW-1:0] pos_ext;
    logic          more_pos;
    logic          scan_more;
    logic          is_less;

    assign in_acc    = i_valid && o_ready;
    assign out_acc   = r_out_vld && i_ready;
    assign has_room  = (r_cnt < CW'(MAX_ITEMS));
    assign n_cnt     = has_room ? (r_cnt + CW'(1)) : r_cnt;
    assign pos_ext   = {1'b0, r_pos};
    assign more_pos  = ((pos_ext + CW'(2)) < r_cnt);
    assign scan_more = (r_scan < r_cnt);
    // The one shared compare: the fetched entry against the running minimum.
    assign is_less   = (i_rdata < r_min_val);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (in_acc && i_is_last) begin
                    n_state = (n_cnt >= CW'(2)) ? ST_POS : ST_ORD;
                end
            end
            ST_POS:    n_state = ST_FIRST;
            ST_FIRST:  n_state = ST_SCAN;
            ST_SCAN: begin
                if (!scan_more) begin
                    n_state = ST_SWAP_A;
                end
            end
            ST_SWAP_A: n_state = ST_SWAP_B;
            ST_SWAP_B: n_state = more_pos ? ST_POS : ST_ORD;
            ST_ORD:    n_state = ST_OEMIT;
            ST_OEMIT:  n_state = ST_OWAIT;
            ST_OWAIT: begin
                if (out_acc) begin
                    n_state = r_out_final ? ST_LOAD : ST_OEMIT;
                end
            end
            default:   n_state = ST_LOAD;
        endcase
    end

    // Store port and handshake outputs.
    always_comb begin
        o_ready = 1'b0;
        o_we    = 1'b0;
        o_waddr = r_pos;
        o_wdata = r_min_val;
        o_raddr = r_pos;
        case (r_state)
            ST_LOAD: begin
                o_ready = 1'b1;
                o_we    = in_acc && has_room;
                o_waddr = r_cnt[AW-1:0];
                o_wdata = i_item_value;
            end
            ST_FIRST,
            ST_SCAN: begin
                o_raddr = r_scan[AW-1:0];
            end
            ST_SWAP_A: begin
                o_we    = 1'b1;
                o_waddr = r_pos;
                o_wdata = r_min_val;
            end
            ST_SWAP_B: begin
                o_we    = 1'b1;
                o_waddr = r_min_at;
                o_wdata = r_pos_val;
            end
            ST_OWAIT: begin
                o_raddr = r_pos + AW'(1);
            end
            default: begin
                o_raddr = r_pos;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_cnt     <= '0;
            r_drop    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_LOAD && in_acc) begin
                r_cnt <= n_cnt;
                if (!has_room) begin
                    r_drop <= 1'b1;
                end
            end
            if (r_state == ST_OEMIT) begin
                r_out_vld <= 1'b1;
            end else if (out_acc) begin
                r_out_vld <= 1'b0;
                if (r_out_final) begin
                    r_cnt  <= '0;
                    r_drop <= 1'b0;
                end
            end
        end
    end

    // Sort and output datapath.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_LOAD: begin
                r_pos <= '0;
            end
            ST_POS: begin
                r_scan <= pos_ext + CW'(1);
            end
            ST_FIRST: begin
                r_min_val <= i_rdata;
                r_pos_val <= i_rdata;
                r_min_at  <= r_pos;
                r_idx     <= r_scan[AW-1:0];
                r_scan    <= r_scan + CW'(1);
            end
            ST_SCAN: begin
                // Strict compare keeps the earliest minimum.
                if (is_less) begin
                    r_min_val <= i_rdata;
                    r_min_at  <= r_idx;
                end
                if (scan_more) begin
                    r_idx  <= r_scan[AW-1:0];
                    r_scan <= r_scan + CW'(1);
                end
            end
            ST_SWAP_B: begin
                r_pos <= more_pos ? (r_pos + AW'(1)) : '0;
            end
            ST_OEMIT: begin
                r_out_val   <= i_rdata;
                r_out_final <= ((pos_ext + CW'(1)) == r_cnt);
                r_out_ovf   <= r_drop;
            end
            ST_OWAIT: begin
                if (out_acc && !r_out_final) begin
                    r_pos <= r_pos + AW'(1);
                end
            end
            default: begin
                r_pos <= r_pos;
            end
        endcase
    end

    assign o_valid        = r_out_vld;
    assign o_sorted_value = r_out_val;
    assign o_is_final     = r_out_final;
    assign o_overflowed   = r_out_ovf;

    // The fill count never passes the store's capacity.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_ITEMS))
        else $error("fill count beyond capacity");

    // Input is never taken while a result is pending.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !r_out_vld)
        else $error("input ready while a result is pending");

    // Taking the final result clears the fill count and drop flag and returns to loading for the next set.
    a_set_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && r_out_final) |=> (r_state == ST_LOAD && r_cnt == '0 && !r_drop))
        else $error("set not closed after final result");

    // An item is dropped only when the store is full.
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !has_room) |-> (r_cnt == CW'(MAX_ITEMS)))
        else $error("item dropped with space left");

endmodule
